// ----- sv/sgcs_pkg.sv -----
package sgcs_pkg;

	localparam int ADDR_WIDTH_DEF = 32;
	localparam int LEN_WIDTH_DEF  = 24;
	localparam int QUEUE_DEPTH    = 2;

	// request codes on the input channel
	localparam logic [1:0] REQ_START = 2'd0;
	localparam logic [1:0] REQ_SRC   = 2'd1;
	localparam logic [1:0] REQ_DST   = 2'd2;

	typedef enum logic [1:0] {
		CMD_START = 2'd0,
		CMD_SRC   = 2'd1,
		CMD_DST   = 2'd2,
		CMD_NOP   = 2'd3
	} cmd_kind_t;

	typedef enum logic [1:0] {
		WANT_SRC  = 2'd0,
		WANT_DST  = 2'd1,
		WANT_BOTH = 2'd2,
		WANT_NONE = 2'd3
	} want_t;

endpackage

// ----- sv/sgcs_front.sv -----
module sgcs_front #(
	parameter int ADDR_WIDTH = sgcs_pkg::ADDR_WIDTH_DEF,
	parameter int LEN_WIDTH  = sgcs_pkg::LEN_WIDTH_DEF
) (
	input  logic [1:0]              req_type,
	input  logic [ADDR_WIDTH-1:0]   desc_addr,
	input  logic [LEN_WIDTH-1:0]    seg_len,
	input  logic                    last_entry,
	input  logic [LEN_WIDTH-1:0]    start_offset,
	input  logic [LEN_WIDTH-1:0]    total_bytes,
	output sgcs_pkg::cmd_kind_t     cmd_kind,
	output logic [ADDR_WIDTH-1:0]   cmd_addr,
	output logic [LEN_WIDTH-1:0]    cmd_len,
	output logic [LEN_WIDTH-1:0]    cmd_aux,
	output logic                    cmd_last
);
	import sgcs_pkg::*;

	// start items reuse the length slot for the offset and carry the total in aux
	always_comb begin
		cmd_kind = CMD_NOP;
		cmd_addr = '0;
		cmd_len  = '0;
		cmd_aux  = '0;
		cmd_last = 1'b0;
		unique case (req_type)
			REQ_START: begin
				cmd_kind = CMD_START;
				cmd_len  = start_offset;
				cmd_aux  = total_bytes;
			end
			REQ_SRC: begin
				cmd_kind = CMD_SRC;
				cmd_addr = desc_addr;
				cmd_len  = seg_len;
				cmd_last = last_entry;
			end
			REQ_DST: begin
				cmd_kind = CMD_DST;
				cmd_addr = desc_addr;
				cmd_len  = seg_len;
				cmd_last = last_entry;
			end
			default: begin
				cmd_kind = CMD_NOP;
			end
		endcase
	end

endmodule

// ----- sv/sgcs_queue.sv -----
module sgcs_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = sgcs_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_stall,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);
	import sgcs_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             push;
	logic             pop;

	assign push_stall = (count_q == CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign push       = push_valid && !push_stall;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- sv/sgcs_back.sv -----
module sgcs_back #(
	parameter int ADDR_WIDTH = sgcs_pkg::ADDR_WIDTH_DEF,
	parameter int LEN_WIDTH  = sgcs_pkg::LEN_WIDTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cmd_valid,
	output logic                    cmd_pop,
	input  sgcs_pkg::cmd_kind_t     cmd_kind,
	input  logic [ADDR_WIDTH-1:0]   cmd_addr,
	input  logic [LEN_WIDTH-1:0]    cmd_len,
	input  logic [LEN_WIDTH-1:0]    cmd_aux,
	input  logic                    cmd_last,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic                    is_copy,
	output logic [ADDR_WIDTH-1:0]   src_addr,
	output logic [ADDR_WIDTH-1:0]   dst_addr,
	output logic [LEN_WIDTH-1:0]    copy_len,
	output logic [1:0]              next_wanted,
	output logic                    done_res,
	output logic [LEN_WIDTH-1:0]    copied_total
);
	import sgcs_pkg::*;

	// transfer state
	logic                  active_q;
	logic [ADDR_WIDTH-1:0] src_seg_addr_q;
	logic [LEN_WIDTH-1:0]  src_seg_len_q;
	logic [LEN_WIDTH-1:0]  src_pos_q;
	logic                  src_held_q;
	logic                  src_is_last_q;
	logic [ADDR_WIDTH-1:0] dst_seg_addr_q;
	logic [LEN_WIDTH-1:0]  dst_seg_len_q;
	logic [LEN_WIDTH-1:0]  dst_pos_q;
	logic                  dst_held_q;
	logic                  dst_is_last_q;
	logic [LEN_WIDTH-1:0]  bytes_left_q;
	logic [LEN_WIDTH-1:0]  bytes_done_q;

	logic                  active_d;
	logic [ADDR_WIDTH-1:0] src_seg_addr_d;
	logic [LEN_WIDTH-1:0]  src_seg_len_d;
	logic [LEN_WIDTH-1:0]  src_pos_d;
	logic                  src_held_d;
	logic                  src_is_last_d;
	logic [ADDR_WIDTH-1:0] dst_seg_addr_d;
	logic [LEN_WIDTH-1:0]  dst_seg_len_d;
	logic [LEN_WIDTH-1:0]  dst_pos_d;
	logic                  dst_held_d;
	logic                  dst_is_last_d;
	logic [LEN_WIDTH-1:0]  bytes_left_d;
	logic [LEN_WIDTH-1:0]  bytes_done_d;

	// result register
	logic                  out_valid_q;
	logic                  is_copy_q;
	logic [ADDR_WIDTH-1:0] src_addr_q;
	logic [ADDR_WIDTH-1:0] dst_addr_q;
	logic [LEN_WIDTH-1:0]  copy_len_q;
	want_t                 next_wanted_q;
	logic                  done_res_q;
	logic [LEN_WIDTH-1:0]  copied_total_q;

	logic                  do_copy;
	logic                  fin;
	logic [LEN_WIDTH-1:0]  avail_s;
	logic [LEN_WIDTH-1:0]  avail_d;
	logic [LEN_WIDTH-1:0]  min_sd;
	logic [LEN_WIDTH-1:0]  n;
	logic                  is_copy_d;
	logic [ADDR_WIDTH-1:0] src_addr_d;
	logic [ADDR_WIDTH-1:0] dst_addr_d;
	want_t                 want_d;
	logic                  out_ready;

	assign out_ready = !out_valid_q || !out_stall;
	assign cmd_pop   = cmd_valid && out_ready;

	always_comb begin
		active_d       = active_q;
		src_seg_addr_d = src_seg_addr_q;
		src_seg_len_d  = src_seg_len_q;
		src_pos_d      = src_pos_q;
		src_held_d     = src_held_q;
		src_is_last_d  = src_is_last_q;
		dst_seg_addr_d = dst_seg_addr_q;
		dst_seg_len_d  = dst_seg_len_q;
		dst_pos_d      = dst_pos_q;
		dst_held_d     = dst_held_q;
		dst_is_last_d  = dst_is_last_q;
		bytes_left_d   = bytes_left_q;
		bytes_done_d   = bytes_done_q;
		do_copy        = 1'b0;
		fin            = 1'b0;
		is_copy_d      = 1'b0;
		src_addr_d     = '0;
		dst_addr_d     = '0;

		unique case (cmd_kind)
			CMD_START: begin
				src_seg_addr_d = '0;
				src_seg_len_d  = '0;
				src_held_d     = 1'b0;
				src_is_last_d  = 1'b0;
				dst_seg_addr_d = '0;
				dst_seg_len_d  = '0;
				dst_pos_d      = '0;
				dst_held_d     = 1'b0;
				dst_is_last_d  = 1'b0;
				bytes_done_d   = '0;
				src_pos_d      = cmd_len;
				bytes_left_d   = cmd_aux;
				active_d       = |cmd_aux;
			end
			CMD_SRC: begin
				if (active_q && !src_held_q) begin
					if (src_pos_q >= cmd_len) begin
						// segment lies wholly inside the start offset
						src_pos_d = src_pos_q - cmd_len;
						if (cmd_last) begin
							active_d   = 1'b0;
							src_held_d = 1'b0;
							dst_held_d = 1'b0;
						end
					end else begin
						src_seg_addr_d = cmd_addr;
						src_seg_len_d  = cmd_len;
						src_is_last_d  = cmd_last;
						src_held_d     = 1'b1;
						do_copy        = dst_held_q;
					end
				end
			end
			CMD_DST: begin
				if (active_q && !dst_held_q) begin
					dst_seg_addr_d = cmd_addr;
					dst_seg_len_d  = cmd_len;
					dst_is_last_d  = cmd_last;
					dst_pos_d      = '0;
					dst_held_d     = 1'b1;
					do_copy        = src_held_q;
				end
			end
			default: begin
			end
		endcase

		avail_s = src_seg_len_d - src_pos_d;
		avail_d = dst_seg_len_d - dst_pos_d;
		min_sd  = (avail_s < avail_d) ? avail_s : avail_d;
		n       = (min_sd < bytes_left_q) ? min_sd : bytes_left_q;

		if (do_copy) begin
			is_copy_d    = 1'b1;
			src_addr_d   = src_seg_addr_d + ADDR_WIDTH'(src_pos_d);
			dst_addr_d   = dst_seg_addr_d + ADDR_WIDTH'(dst_pos_d);
			bytes_done_d = bytes_done_q + n;
			bytes_left_d = bytes_left_q - n;
			if (n == avail_s) begin
				src_held_d = 1'b0;
				src_pos_d  = '0;
				fin        = src_is_last_d;
			end else begin
				src_pos_d = src_pos_d + n;
			end
			// an exhausted last source ends the transfer before dst moves
			if (!fin) begin
				if (n == avail_d) begin
					dst_held_d = 1'b0;
					dst_pos_d  = '0;
					fin        = dst_is_last_d;
				end else begin
					dst_pos_d = dst_pos_d + n;
				end
				if (bytes_left_d == '0) begin
					fin = 1'b1;
				end
			end
			if (fin) begin
				active_d   = 1'b0;
				src_held_d = 1'b0;
				dst_held_d = 1'b0;
			end
		end

		priority if (!active_d) begin
			want_d = WANT_NONE;
		end else if (!src_held_d && !dst_held_d) begin
			want_d = WANT_BOTH;
		end else if (!src_held_d) begin
			want_d = WANT_SRC;
		end else if (!dst_held_d) begin
			want_d = WANT_DST;
		end else begin
			want_d = WANT_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q       <= 1'b0;
			src_seg_addr_q <= '0;
			src_seg_len_q  <= '0;
			src_pos_q      <= '0;
			src_held_q     <= 1'b0;
			src_is_last_q  <= 1'b0;
			dst_seg_addr_q <= '0;
			dst_seg_len_q  <= '0;
			dst_pos_q      <= '0;
			dst_held_q     <= 1'b0;
			dst_is_last_q  <= 1'b0;
			bytes_left_q   <= '0;
			bytes_done_q   <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (out_ready) begin
				out_valid_q <= cmd_valid;
			end
			if (cmd_pop) begin
				active_q       <= active_d;
				src_seg_addr_q <= src_seg_addr_d;
				src_seg_len_q  <= src_seg_len_d;
				src_pos_q      <= src_pos_d;
				src_held_q     <= src_held_d;
				src_is_last_q  <= src_is_last_d;
				dst_seg_addr_q <= dst_seg_addr_d;
				dst_seg_len_q  <= dst_seg_len_d;
				dst_pos_q      <= dst_pos_d;
				dst_held_q     <= dst_held_d;
				dst_is_last_q  <= dst_is_last_d;
				bytes_left_q   <= bytes_left_d;
				bytes_done_q   <= bytes_done_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			is_copy_q      <= is_copy_d;
			src_addr_q     <= src_addr_d;
			dst_addr_q     <= dst_addr_d;
			copy_len_q     <= do_copy ? n : '0;
			next_wanted_q  <= want_d;
			done_res_q     <= !active_d;
			copied_total_q <= bytes_done_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign is_copy      = is_copy_q;
	assign src_addr     = src_addr_q;
	assign dst_addr     = dst_addr_q;
	assign copy_len     = copy_len_q;
	assign next_wanted  = next_wanted_q;
	assign done_res     = done_res_q;
	assign copied_total = copied_total_q;

endmodule

// ----- sv/scatter_gather_copy_segmenter_core.sv -----
// Scatter-gather copy planner. Send a start transaction (offset, total), then source and
// destination descriptors; every input transaction yields exactly one result carrying
// either a copy segment (source address, destination address, length) or just status:
// which descriptor kind is wanted next, whether the transfer is done, and the running
// byte count. Throughput is one transaction per cycle sustained while out_stall is low;
// an accepted transaction is written into the two-entry command queue, then popped
// into the result register. The back end computes all segment state for one
// transaction combinationally and registers it on the pop, which sets that rate.
// in_stall rises only when the queue is full.
module scatter_gather_copy_segmenter_core #(
	parameter int ADDR_WIDTH = sgcs_pkg::ADDR_WIDTH_DEF,
	parameter int LEN_WIDTH  = sgcs_pkg::LEN_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [1:0]            req_type,
	input  logic [ADDR_WIDTH-1:0] desc_addr,
	input  logic [LEN_WIDTH-1:0]  seg_len,
	input  logic                  last_entry,
	input  logic [LEN_WIDTH-1:0]  start_offset,
	input  logic [LEN_WIDTH-1:0]  total_bytes,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  is_copy,
	output logic [ADDR_WIDTH-1:0] src_addr,
	output logic [ADDR_WIDTH-1:0] dst_addr,
	output logic [LEN_WIDTH-1:0]  copy_len,
	output logic [1:0]            next_wanted,
	output logic                  done_res,
	output logic [LEN_WIDTH-1:0]  copied_total
);
	import sgcs_pkg::*;

	localparam int QW = 2 + ADDR_WIDTH + 2 * LEN_WIDTH + 1;

	cmd_kind_t             f_kind;
	logic [ADDR_WIDTH-1:0] f_addr;
	logic [LEN_WIDTH-1:0]  f_len;
	logic [LEN_WIDTH-1:0]  f_aux;
	logic                  f_last;
	logic [QW-1:0]         push_data;
	logic [QW-1:0]         pop_data;
	logic                  q_valid;
	logic                  q_pop;
	cmd_kind_t             b_kind;
	logic [ADDR_WIDTH-1:0] b_addr;
	logic [LEN_WIDTH-1:0]  b_len;
	logic [LEN_WIDTH-1:0]  b_aux;
	logic                  b_last;

	sgcs_front #(
		.ADDR_WIDTH (ADDR_WIDTH),
		.LEN_WIDTH  (LEN_WIDTH)
	) u_front (
		.req_type     (req_type),
		.desc_addr    (desc_addr),
		.seg_len      (seg_len),
		.last_entry   (last_entry),
		.start_offset (start_offset),
		.total_bytes  (total_bytes),
		.cmd_kind     (f_kind),
		.cmd_addr     (f_addr),
		.cmd_len      (f_len),
		.cmd_aux      (f_aux),
		.cmd_last     (f_last)
	);

	assign push_data = {f_kind, f_addr, f_len, f_aux, f_last};

	sgcs_queue #(
		.WIDTH (QW),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (in_valid),
		.push_stall (in_stall),
		.push_data  (push_data),
		.pop_valid  (q_valid),
		.pop_ready  (q_pop),
		.pop_data   (pop_data)
	);

	assign b_kind = cmd_kind_t'(pop_data[QW-1 -: 2]);
	assign b_addr = pop_data[QW-3 -: ADDR_WIDTH];
	assign b_len  = pop_data[2*LEN_WIDTH : LEN_WIDTH+1];
	assign b_aux  = pop_data[LEN_WIDTH : 1];
	assign b_last = pop_data[0];

	sgcs_back #(
		.ADDR_WIDTH (ADDR_WIDTH),
		.LEN_WIDTH  (LEN_WIDTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (q_valid),
		.cmd_pop      (q_pop),
		.cmd_kind     (b_kind),
		.cmd_addr     (b_addr),
		.cmd_len      (b_len),
		.cmd_aux      (b_aux),
		.cmd_last     (b_last),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.is_copy      (is_copy),
		.src_addr     (src_addr),
		.dst_addr     (dst_addr),
		.copy_len     (copy_len),
		.next_wanted  (next_wanted),
		.done_res     (done_res),
		.copied_total (copied_total)
	);

endmodule

// ----- verif/scatter_gather_copy_segmenter_checker.sv -----
module scatter_gather_copy_segmenter_checker #(
	parameter int AW = sgcs_pkg::ADDR_WIDTH_DEF,
	parameter int LW = sgcs_pkg::LEN_WIDTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          in_stall,
	input  logic [1:0]    req_type,
	input  logic [AW-1:0] desc_addr,
	input  logic [LW-1:0] seg_len,
	input  logic          last_entry,
	input  logic [LW-1:0] start_offset,
	input  logic [LW-1:0] total_bytes,
	input  logic          out_valid,
	input  logic          out_stall,
	input  logic          is_copy,
	input  logic [AW-1:0] src_addr,
	input  logic [AW-1:0] dst_addr,
	input  logic [LW-1:0] copy_len,
	input  logic [1:0]    next_wanted,
	input  logic          done_res,
	input  logic [LW-1:0] copied_total,
	output int            fail_count,
	output int            pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import sgcs_pkg::*;

	typedef struct packed {
		logic          is_copy;
		logic [AW-1:0] src_addr;
		logic [AW-1:0] dst_addr;
		logic [LW-1:0] copy_len;
		want_t         next_wanted;
		logic          done_res;
		logic [LW-1:0] copied_total;
	} segment_plan_t;

	segment_plan_t planned_q[$];

	// planner state
	logic          xfer_active;
	logic [AW-1:0] src_base;
	logic [LW-1:0] src_size, src_off;
	logic          src_valid, src_final;
	logic [AW-1:0] dst_base;
	logic [LW-1:0] dst_size, dst_off;
	logic          dst_valid, dst_final;
	logic [LW-1:0] remaining, planned_bytes;

	initial begin
		fail_count = 0;
		pending    = 0;
	end

	task automatic clear_plan_state();
		xfer_active   = 1'b0;
		src_base      = '0;
		src_size      = '0;
		src_off       = '0;
		src_valid     = 1'b0;
		src_final     = 1'b0;
		dst_base      = '0;
		dst_size      = '0;
		dst_off       = '0;
		dst_valid     = 1'b0;
		dst_final     = 1'b0;
		remaining     = '0;
		planned_bytes = '0;
	endtask

	task automatic end_transfer();
		xfer_active = 1'b0;
		src_valid   = 1'b0;
		dst_valid   = 1'b0;
	endtask

	task automatic cut_segment(inout segment_plan_t p);
		logic [LW-1:0] src_room, dst_room, n;
		bit ended;
		if (xfer_active && src_valid && dst_valid) begin
			src_room = src_size - src_off;
			dst_room = dst_size - dst_off;
			n = (src_room < dst_room) ? src_room : dst_room;
			if (remaining < n)
				n = remaining;
			p.is_copy  = 1'b1;
			p.src_addr = src_base + AW'(src_off);
			p.dst_addr = dst_base + AW'(dst_off);
			p.copy_len = n;
			planned_bytes = planned_bytes + n;
			remaining = remaining - n;
			ended = 1'b0;
			if (n == src_room) begin
				src_valid = 1'b0;
				src_off = '0;
				if (src_final) begin
					end_transfer();
					ended = 1'b1;
				end
			end else begin
				src_off = src_off + n;
			end
			if (!ended) begin
				if (n == dst_room) begin
					dst_valid = 1'b0;
					dst_off = '0;
					if (dst_final) begin
						end_transfer();
						ended = 1'b1;
					end
				end else begin
					dst_off = dst_off + n;
				end
				if (!ended && remaining == '0)
					end_transfer();
			end
		end
	endtask

	task automatic plan_transaction(input logic [1:0] kind, input logic [AW-1:0] addr,
			input logic [LW-1:0] len, input logic last, input logic [LW-1:0] offs,
			input logic [LW-1:0] total, output segment_plan_t p);
		p = '0;
		case (kind)
			CMD_START: begin
				clear_plan_state();
				src_off = offs;
				remaining = total;
				xfer_active = (total != '0);
			end
			CMD_SRC: begin
				if (xfer_active && !src_valid) begin
					// segment lying wholly inside the start offset is skipped
					if (src_off >= len) begin
						src_off = src_off - len;
						if (last)
							end_transfer();
					end else begin
						src_base  = addr;
						src_size  = len;
						src_final = last;
						src_valid = 1'b1;
						cut_segment(p);
					end
				end
			end
			CMD_DST: begin
				if (xfer_active && !dst_valid) begin
					dst_base  = addr;
					dst_size  = len;
					dst_final = last;
					dst_off   = '0;
					dst_valid = 1'b1;
					cut_segment(p);
				end
			end
			default: ;
		endcase
		if (!xfer_active)
			p.next_wanted = WANT_NONE;
		else if (!src_valid && !dst_valid)
			p.next_wanted = WANT_BOTH;
		else if (!src_valid)
			p.next_wanted = WANT_SRC;
		else if (!dst_valid)
			p.next_wanted = WANT_DST;
		else
			p.next_wanted = WANT_NONE;
		p.done_res = !xfer_active;
		p.copied_total = planned_bytes;
	endtask

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		if (fail_count < 40)
			$display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		segment_plan_t p, exp_r;
		if (!arst_n) begin
			clear_plan_state();
			planned_q.delete();
			pending <= 0;
		end else begin
			// compare first so a stray result is never matched to this cycle's input
			if (out_valid && !out_stall) begin
				if (planned_q.size() == 0) begin
					report_mismatch("result with nothing outstanding", copied_total, 0);
				end else begin
					exp_r = planned_q.pop_front();
					if (is_copy !== exp_r.is_copy)
						report_mismatch("is_copy", is_copy, exp_r.is_copy);
					if (src_addr !== exp_r.src_addr)
						report_mismatch("src_addr", src_addr, exp_r.src_addr);
					if (dst_addr !== exp_r.dst_addr)
						report_mismatch("dst_addr", dst_addr, exp_r.dst_addr);
					if (copy_len !== exp_r.copy_len)
						report_mismatch("copy_len", copy_len, exp_r.copy_len);
					if (next_wanted !== exp_r.next_wanted)
						report_mismatch("next_wanted", next_wanted, exp_r.next_wanted);
					if (done_res !== exp_r.done_res)
						report_mismatch("done_res", done_res, exp_r.done_res);
					if (copied_total !== exp_r.copied_total)
						report_mismatch("copied_total", copied_total, exp_r.copied_total);
				end
			end
			if (in_valid && !in_stall) begin
				plan_transaction(req_type, desc_addr, seg_len, last_entry, start_offset,
					total_bytes, p);
				planned_q.push_back(p);
			end
			pending <= planned_q.size();
		end
	end

endmodule

// ----- verif/tb_scatter_gather_copy_segmenter_core.sv -----
module tb_scatter_gather_copy_segmenter_core;
	timeunit 1ns;
	timeprecision 1ps;
	import sgcs_pkg::*;

	localparam int AW          = ADDR_WIDTH_DEF;
	localparam int LW          = LEN_WIDTH_DEF;
	localparam int ITEM_TARGET = 1350;
	localparam int CYCLE_LIMIT = 600000;

	logic          clk;
	logic          arst_n;
	logic          in_valid;
	logic          in_stall;
	logic [1:0]    req_type;
	logic [AW-1:0] desc_addr;
	logic [LW-1:0] seg_len;
	logic          last_entry;
	logic [LW-1:0] start_offset;
	logic [LW-1:0] total_bytes;
	logic          out_valid;
	logic          out_stall;
	logic          is_copy;
	logic [AW-1:0] src_addr;
	logic [AW-1:0] dst_addr;
	logic [LW-1:0] copy_len;
	logic [1:0]    next_wanted;
	logic          done_res;
	logic [LW-1:0] copied_total;
	int            fail_count;
	int            pending;

	bit calm;
	int cycle_cnt;
	int sent;

	scatter_gather_copy_segmenter_core u_dut (.*);

	scatter_gather_copy_segmenter_checker u_checker (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// called just after an edge; returns at the edge the transaction is taken
	task automatic send_item(input cmd_kind_t kind, input logic [AW-1:0] addr,
			input logic [LW-1:0] len, input logic last, input logic [LW-1:0] offs,
			input logic [LW-1:0] total);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		req_type     <= kind;
		desc_addr    <= addr;
		seg_len      <= len;
		last_entry   <= last;
		start_offset <= offs;
		total_bytes  <= total;
		do @(posedge clk); while (in_stall);
		sent++;
	endtask

	function automatic logic [LW-1:0] pick_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return '0;
		else if (r < 85)
			return LW'($urandom_range(1, 64));
		else if (r < 95)
			return LW'($urandom_range(65, 4096));
		else if (r < 99)
			return LW'($urandom);
		return '1;
	endfunction

	function automatic logic [AW-1:0] pick_addr();
		int r;
		r = $urandom_range(0, 19);
		if (r < 2)
			return {AW{1'b1}} - AW'($urandom_range(0, 255));
		else if (r < 3)
			return AW'($urandom_range(0, 255));
		return AW'($urandom);
	endfunction

	function automatic logic [LW-1:0] pick_offset();
		int r;
		r = $urandom_range(0, 19);
		if (r < 10)
			return '0;
		else if (r < 17)
			return LW'($urandom_range(1, 128));
		else if (r < 19)
			return LW'($urandom);
		return '1;
	endfunction

	function automatic logic [LW-1:0] pick_total();
		int r;
		r = $urandom_range(0, 19);
		if (r < 1)
			return '0;
		else if (r < 2)
			return '1;
		else if (r < 16)
			return LW'($urandom_range(1, 300));
		return LW'($urandom);
	endfunction

	task automatic run_transfer();
		int n_desc, r;
		cmd_kind_t kind, prev;
		send_item(CMD_START, pick_addr(), pick_len(), 1'($urandom), pick_offset(),
			pick_total());
		n_desc = $urandom_range(0, 14);
		prev = ($urandom_range(0, 1) == 0) ? CMD_SRC : CMD_DST;
		for (int i = 0; i < n_desc; i++) begin
			r = $urandom_range(0, 99);
			if (r < 5) begin
				// junk: unknown request code
				send_item(CMD_NOP, AW'($urandom), LW'($urandom), 1'($urandom),
					LW'($urandom), LW'($urandom));
			end else begin
				if (r < 75)
					kind = (prev == CMD_SRC) ? CMD_DST : CMD_SRC;
				else
					kind = prev;
				prev = kind;
				send_item(kind, pick_addr(), pick_len(), ($urandom_range(0, 6) == 0),
					LW'($urandom), LW'($urandom));
			end
		end
	endtask

	initial begin
		out_stall = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			int gap;
			gap = calm ? 0 : $urandom_range(0, 18);
			if (gap > 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin
		clk          = 1'b0;
		arst_n       = 1'b0;
		cycle_cnt    = 0;
		sent         = 0;
		calm         = 1'b0;
		in_valid     = 1'b0;
		req_type     = CMD_NOP;
		desc_addr    = '0;
		seg_len      = '0;
		last_entry   = 1'b0;
		start_offset = '0;
		total_bytes  = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// idle block: descriptors and junk only report status
		send_item(CMD_SRC, 32'h1234_5678, 24'd16, 1'b1, '1, '1);
		send_item(CMD_NOP, '1, '1, 1'b1, '1, '1);
		send_item(CMD_START, '0, '0, 1'b0, 24'd5, 24'd0);
		send_item(CMD_DST, 32'h0000_0040, 24'd8, 1'b0, '0, '0);
		// full-size total, wrapping addresses, empty destination, extra source
		send_item(CMD_START, '1, '1, 1'b1, 24'd0, 24'hFF_FFFF);
		send_item(CMD_SRC, 32'hFFFF_FFF0, 24'd32, 1'b0, '0, '0);
		send_item(CMD_SRC, 32'hAAAA_0000, 24'd8, 1'b0, '0, '0);
		send_item(CMD_DST, 32'hFFFF_FFF8, 24'd0, 1'b0, '0, '0);
		send_item(CMD_DST, 32'h0000_0100, 24'd16, 1'b0, '0, '0);
		send_item(CMD_DST, 32'hFFFF_FFFC, 24'hFF_FFFF, 1'b1, '0, '0);
		send_item(CMD_SRC, 32'h8000_0000, 24'hFF_FFFF, 1'b1, '0, '0);
		// offset skips an empty source, a short one and one ending exactly on it
		send_item(CMD_START, '0, '0, 1'b0, 24'd100, 24'd50);
		send_item(CMD_SRC, 32'h0000_0500, 24'd0, 1'b0, '0, '0);
		send_item(CMD_SRC, 32'h0000_0600, 24'd60, 1'b0, '0, '0);
		send_item(CMD_SRC, 32'h0000_0700, 24'd40, 1'b0, '0, '0);
		send_item(CMD_SRC, 32'h0000_1000, 24'd100, 1'b0, '0, '0);
		send_item(CMD_DST, 32'h0000_2000, 24'd200, 1'b1, '0, '0);
		// restart while running, then a skipped last source ends the transfer
		send_item(CMD_START, '0, '0, 1'b0, 24'd0, 24'd10);
		send_item(CMD_SRC, 32'h0000_3000, 24'd5, 1'b1, '0, '0);
		send_item(CMD_START, '0, '0, 1'b0, 24'd10, 24'd5);
		send_item(CMD_SRC, 32'h0000_4000, 24'd4, 1'b1, '0, '0);
		// last destination ends it
		send_item(CMD_START, '0, '0, 1'b0, 24'd0, 24'd100);
		send_item(CMD_SRC, 32'h0000_5000, 24'd100, 1'b0, '0, '0);
		send_item(CMD_DST, 32'h0000_6000, 24'd30, 1'b1, '0, '0);
		send_item(CMD_START, '0, '0, 1'b0, 24'hFF_FFFF, 24'd1);
		send_item(CMD_SRC, 32'h0000_7000, 24'hFF_FFFF, 1'b0, '0, '0);

		while (sent < ITEM_TARGET) begin
			calm = ($urandom_range(0, 9) == 0);
			run_transfer();
		end
		calm = 1'b0;
		in_valid <= 1'b0;

		do @(posedge clk); while (pending != 0);
		repeat (16) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ----- scatter_gather_copy_segmenter_core.f -----
sv/sgcs_pkg.sv
sv/sgcs_front.sv
sv/sgcs_queue.sv
sv/sgcs_back.sv
sv/scatter_gather_copy_segmenter_core.sv
verif/scatter_gather_copy_segmenter_checker.sv
verif/tb_scatter_gather_copy_segmenter_core.sv
